// ===== src/cmsc_pkg.sv =====
// Package for the counter multiplier and shift calculator.
// Holds the constants, widths and the sequencer state type used by the
// interfaces, the divider and the top level. It depends on nothing.
package cmsc_pkg;

	localparam int FREQ_W  = 32;
	localparam int MULT_W  = 32;
	localparam int SHIFT_W = 6;
	localparam int SCALE_W = 10;
	localparam int DVD_W   = 64;
	localparam int DVS_W   = 32;
	localparam int SEC_W   = 10;
	localparam int RANGE_W = SEC_W + SCALE_W;
	localparam int CNTR_W  = 6;
	localparam int ADJ_W   = MULT_W + 7;

	localparam logic [DVD_W-1:0]   CNT_MAX   = 64'h00FF_FFFF_FFFF_FFFF;
	localparam logic [SEC_W-1:0]   SEC_LIMIT = 10'd600;
	localparam logic [DVS_W-1:0]   ADJ_DIV   = 32'd100;
	localparam logic [SHIFT_W-1:0] SHIFT_TOP = 6'd32;
	localparam logic [DVD_W-1:0]   NS_PER_S  = 64'd1000000000;
	localparam logic [SCALE_W-1:0] SCALE_RST = 10'd1;

	// A multiplier m wraps when m plus 11 percent of it reaches 2^32, which holds
	// exactly when 111 * m is at least 100 * 2^32.
	localparam logic [ADJ_W-1:0]   ADJ_MUL   = 39'd111;
	localparam logic [ADJ_W-1:0]   ADJ_WRAP  = 39'd100 << 32;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEC_GO,
		ST_SEC_WT,
		ST_SECS_GO,
		ST_SECS_WT,
		ST_TGT_GO,
		ST_TGT_WT,
		ST_RANGE,
		ST_ACC,
		ST_HEAD,
		ST_TRIAL_GO,
		ST_TRIAL_WT,
		ST_ADJ,
		ST_OUT
	} state_t;

endpackage

// ===== src/cmsc_if.sv =====
// Channel interfaces for the counter multiplier and shift calculator.
// Each carries valid, ready and its payload; widths come from cmsc_pkg.
interface cmsc_freq_if;
	logic                         valid;
	logic                         ready;
	logic [cmsc_pkg::FREQ_W-1:0]  frequency;
	modport source (output valid, output frequency, input ready);
	modport sink (input valid, input frequency, output ready);
endinterface

interface cmsc_res_if;
	logic                         valid;
	logic                         ready;
	logic [cmsc_pkg::MULT_W-1:0]  mult_out;
	logic [cmsc_pkg::SHIFT_W-1:0] shift_out;
	modport source (output valid, output mult_out, output shift_out, input ready);
	modport sink (input valid, input mult_out, input shift_out, output ready);
endinterface

interface cmsc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [cmsc_pkg::SCALE_W-1:0] scale_factor;
	modport source (output valid, output scale_factor, input ready);
	modport sink (input valid, input scale_factor, output ready);
endinterface

// ===== src/cmsc_div.sv =====
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor.
// One quotient bit per cycle; done is high for a single cycle, registered with the last bit.
// Depends on cmsc_pkg for widths.
module cmsc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cmsc_pkg::DVD_W-1:0]  dividend,
	input  logic [cmsc_pkg::DVS_W-1:0]  divisor,
	output logic                        done,
	output logic [cmsc_pkg::DVD_W-1:0]  quotient
);

	logic                        busy_q;
	logic                        done_q;
	logic [cmsc_pkg::CNTR_W-1:0] cnt_q;
	logic [cmsc_pkg::DVD_W-1:0]  quo_q;
	logic [cmsc_pkg::DVS_W-1:0]  rem_q;
	logic [cmsc_pkg::DVS_W-1:0]  dvs_q;
	logic [cmsc_pkg::DVS_W:0]    trial_rem;
	logic [cmsc_pkg::DVS_W:0]    diff;
	logic                        ge;

	always_comb begin
		trial_rem = {rem_q, quo_q[cmsc_pkg::DVD_W-1]};
		diff      = trial_rem - {1'b0, dvs_q};
		ge        = trial_rem >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == {cmsc_pkg::CNTR_W{1'b1}}) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[cmsc_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? diff[cmsc_pkg::DVS_W-1:0] : trial_rem[cmsc_pkg::DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/counter_mult_shift_calc_top.sv =====
// Top level of the counter multiplier and shift calculator.
// Depends on cmsc_pkg, the channel interfaces in cmsc_if and the divider cmsc_div.
//
// Channel  Dir  Payload                      Transfer
// req      in   frequency[31:0]              valid & ready
// rsp      out  mult_out[31:0], shift_out[5:0] valid & ready
// cfg      in   scale_factor[9:0]            valid & ready (always ready)
//
// A zero frequency skips the divider. Otherwise the shared divider runs three
// set-up divisions and one per trial shift (up to 32); the range product, the
// headroom count and the adjustment steps come on top. The block takes one item
// at a time; a new item is accepted while the previous result still waits, and a
// finished result waits for the output register.
// Reset clears the stored pair and sets the scale to 1.
module counter_mult_shift_calc_top (
	input logic              clk,
	input logic              arst_n,
	cmsc_freq_if.sink        req,
	cmsc_res_if.source       rsp,
	cmsc_cfg_if.sink         cfg
);

	cmsc_pkg::state_t state_q, state_d;

	logic [cmsc_pkg::SCALE_W-1:0] scale_q;
	logic [cmsc_pkg::SCALE_W-1:0] scale;
	logic [cmsc_pkg::FREQ_W-1:0]  freq_q;
	logic [cmsc_pkg::DVD_W-1:0]   sec_raw_q;
	logic [cmsc_pkg::SEC_W-1:0]   sec_q;
	logic [29:0]                  target_q;
	logic [cmsc_pkg::RANGE_W-1:0] range_q;
	logic [cmsc_pkg::RANGE_W-1:0] acc_q;
	logic [cmsc_pkg::SHIFT_W-1:0] head_q;
	logic [cmsc_pkg::SHIFT_W-1:0] sft_q;
	logic [cmsc_pkg::MULT_W-1:0]  mult_q;
	logic [cmsc_pkg::SHIFT_W-1:0] shift_q;
	logic                         out_valid_q;
	logic [cmsc_pkg::MULT_W-1:0]  out_mult_q;
	logic [cmsc_pkg::SHIFT_W-1:0] out_shift_q;

	logic                         div_start;
	logic [cmsc_pkg::DVD_W-1:0]   div_dvd;
	logic [cmsc_pkg::DVS_W-1:0]   div_dvs;
	logic                         div_done;
	logic [cmsc_pkg::DVD_W-1:0]   div_quo;

	logic                         in_xfer;
	logic                         out_free;
	logic                         out_load;
	logic                         fit;
	logic                         last_sft;
	logic                         wrap;
	logic [cmsc_pkg::RANGE_W+cmsc_pkg::FREQ_W-1:0] prod;
	logic [cmsc_pkg::ADJ_W-1:0]   m_adj;

	cmsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		scale    = (scale_q == '0) ? cmsc_pkg::SCALE_RST : scale_q;
		in_xfer  = req.valid && req.ready;
		out_free = !out_valid_q || rsp.ready;
		fit      = (div_quo >> head_q) == '0;
		last_sft = sft_q == 6'd1;
		prod     = {{cmsc_pkg::FREQ_W{1'b0}}, range_q} * {{cmsc_pkg::RANGE_W{1'b0}}, freq_q};
		m_adj    = {{(cmsc_pkg::ADJ_W-cmsc_pkg::MULT_W){1'b0}}, mult_q} * cmsc_pkg::ADJ_MUL;
		wrap     = m_adj >= cmsc_pkg::ADJ_WRAP;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cmsc_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = (req.frequency == '0) ? cmsc_pkg::ST_OUT : cmsc_pkg::ST_SEC_GO;
				end
			end
			cmsc_pkg::ST_SEC_GO:  state_d = cmsc_pkg::ST_SEC_WT;
			cmsc_pkg::ST_SEC_WT:  if (div_done) state_d = cmsc_pkg::ST_SECS_GO;
			cmsc_pkg::ST_SECS_GO: state_d = cmsc_pkg::ST_SECS_WT;
			cmsc_pkg::ST_SECS_WT: if (div_done) state_d = cmsc_pkg::ST_TGT_GO;
			cmsc_pkg::ST_TGT_GO:  state_d = cmsc_pkg::ST_TGT_WT;
			cmsc_pkg::ST_TGT_WT:  if (div_done) state_d = cmsc_pkg::ST_RANGE;
			cmsc_pkg::ST_RANGE:   state_d = cmsc_pkg::ST_ACC;
			cmsc_pkg::ST_ACC:     state_d = cmsc_pkg::ST_HEAD;
			cmsc_pkg::ST_HEAD: begin
				if (acc_q == '0 || head_q == '0) begin
					state_d = cmsc_pkg::ST_TRIAL_GO;
				end
			end
			cmsc_pkg::ST_TRIAL_GO: state_d = cmsc_pkg::ST_TRIAL_WT;
			cmsc_pkg::ST_TRIAL_WT: begin
				if (div_done) begin
					state_d = (fit || last_sft) ? cmsc_pkg::ST_ADJ : cmsc_pkg::ST_TRIAL_GO;
				end
			end
			cmsc_pkg::ST_ADJ: state_d = wrap ? cmsc_pkg::ST_ADJ : cmsc_pkg::ST_OUT;
			cmsc_pkg::ST_OUT: if (out_free) state_d = cmsc_pkg::ST_IDLE;
			default: state_d = cmsc_pkg::ST_IDLE;
		endcase
	end

	// Output and divider operand logic.
	always_comb begin
		req.ready = 1'b0;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = freq_q;
		out_load  = 1'b0;
		unique case (state_q)
			cmsc_pkg::ST_IDLE: req.ready = 1'b1;
			cmsc_pkg::ST_SEC_GO: begin
				div_start = 1'b1;
				div_dvd   = cmsc_pkg::CNT_MAX;
			end
			cmsc_pkg::ST_SECS_GO: begin
				div_start = 1'b1;
				div_dvd   = sec_raw_q;
				div_dvs   = {{(cmsc_pkg::DVS_W-cmsc_pkg::SCALE_W){1'b0}}, scale};
			end
			cmsc_pkg::ST_TGT_GO: begin
				div_start = 1'b1;
				div_dvd   = cmsc_pkg::NS_PER_S;
				div_dvs   = {{(cmsc_pkg::DVS_W-cmsc_pkg::SCALE_W){1'b0}}, scale};
			end
			cmsc_pkg::ST_TRIAL_GO: begin
				div_start = 1'b1;
				div_dvd   = ({34'b0, target_q} << sft_q) + {33'b0, freq_q[31:1]};
			end
			cmsc_pkg::ST_OUT: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cmsc_pkg::ST_IDLE;
			scale_q     <= cmsc_pkg::SCALE_RST;
			mult_q      <= '0;
			shift_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				scale_q <= cfg.scale_factor;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == cmsc_pkg::ST_TRIAL_WT && div_done && (fit || last_sft)) begin
				mult_q  <= div_quo[cmsc_pkg::MULT_W-1:0];
				shift_q <= fit ? sft_q : '0;
			end
			if (state_q == cmsc_pkg::ST_ADJ && wrap) begin
				mult_q  <= mult_q >> 1;
				shift_q <= (shift_q != '0) ? shift_q - 1'b1 : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			freq_q <= req.frequency;
		end
		if (state_q == cmsc_pkg::ST_SEC_WT && div_done) begin
			sec_raw_q <= div_quo;
		end
		if (state_q == cmsc_pkg::ST_SECS_WT && div_done) begin
			if (div_quo == '0) begin
				sec_q <= cmsc_pkg::SEC_W'(1);
			end else if (div_quo > {54'b0, cmsc_pkg::SEC_LIMIT}) begin
				sec_q <= cmsc_pkg::SEC_LIMIT;
			end else begin
				sec_q <= div_quo[cmsc_pkg::SEC_W-1:0];
			end
		end
		if (state_q == cmsc_pkg::ST_TGT_WT && div_done) begin
			target_q <= div_quo[29:0];
		end
		if (state_q == cmsc_pkg::ST_RANGE) begin
			range_q <= {{cmsc_pkg::SCALE_W{1'b0}}, sec_q} * {{cmsc_pkg::SEC_W{1'b0}}, scale};
		end
		if (state_q == cmsc_pkg::ST_ACC) begin
			acc_q  <= prod[cmsc_pkg::RANGE_W+cmsc_pkg::FREQ_W-1:cmsc_pkg::FREQ_W];
			head_q <= cmsc_pkg::SHIFT_TOP;
		end
		if (state_q == cmsc_pkg::ST_HEAD) begin
			if (acc_q != '0 && head_q != '0) begin
				acc_q  <= acc_q >> 1;
				head_q <= head_q - 1'b1;
			end else begin
				sft_q <= cmsc_pkg::SHIFT_TOP;
			end
		end
		if (state_q == cmsc_pkg::ST_TRIAL_WT && div_done && !(fit || last_sft)) begin
			sft_q <= sft_q - 1'b1;
		end
		if (out_load) begin
			out_mult_q  <= mult_q;
			out_shift_q <= shift_q;
		end
	end

	assign cfg.ready     = 1'b1;
	assign rsp.valid     = out_valid_q;
	assign rsp.mult_out  = out_mult_q;
	assign rsp.shift_out = out_shift_q;

endmodule
